/* rtl/core/tti_pkg.sv */
// shared types and constants for the timed track interpolator
package tti_pkg;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int PT_W = 106;

    // datapath commands
    typedef struct packed {
        logic clear;
        logic append;
        logic start_query;
        logic search_rd;
        logic search_upd;
        logic rd_s1;
        logic cap_s;
        logic cap_s1;
        logic div_start;
        logic out_empty;
        logic out_point;
        logic out_interp;
    } cmd_t;

    // datapath status
    typedef struct packed {
        logic empty;
        logic search_done;
        logic use_point;
        logic div_done;
    } stat_t;

endpackage

/* rtl/core/tti_divider.sv */
// restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle
module tti_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] q_reg;
    logic [32:0] r_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] sub;

    assign trial = {r_reg[31:0], q_reg[63]};
    assign sub   = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!sub[32])
            begin
                r_reg <= sub;
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/core/tti_datapath.sv */
// table memory, search registers, interpolation arithmetic and output register
module tti_datapath #(
    parameter int MAX_POINTS = 4096,
    parameter int AW = 12,
    parameter int CW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tti_pkg::cmd_t cmd,
    output tti_pkg::stat_t stat,
    input  logic [31:0]   track_start,
    input  logic [31:0]   point_time,
    input  logic [31:0]   point_lat,
    input  logic [31:0]   point_lon,
    input  logic [9:0]    point_speed,
    input  logic [31:0]   query_time,
    input  logic          interpolate,
    output logic          found,
    output logic [31:0]   out_lat,
    output logic [31:0]   out_lon,
    output logic [9:0]    out_speed,
    output logic [31:0]   out_time
);

    typedef enum logic [1:0] {
        D_IDLE, D_MAG, D_MUL, D_DIV
    } dstate_t;

    logic [tti_pkg::PT_W-1:0] mem [MAX_POINTS];
    logic [tti_pkg::PT_W-1:0] rd_reg;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] first_reg, cnt_reg, step_reg;
    logic [CW-1:0] s_idx;
    logic [32:0]   pos_reg;
    logic          interp_reg;

    logic [31:0] t0_reg, t1_reg, lat0_reg, lat1_reg, lon0_reg, lon1_reg;
    logic [9:0]  spd0_reg;
    logic        lon_phase_reg;
    logic [32:0] mag_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    logic        div_start_reg, div_done;
    logic [63:0] quot;
    logic [31:0] frac, whole;
    logic [32:0] diff;
    logic [31:0] lat_res_reg;
    dstate_t     dstate_reg;

    logic        found_reg;
    logic [31:0] out_lat_reg, out_lon_reg, out_time_reg;
    logic [9:0]  out_speed_reg;

    assign s_idx = (first_reg != '0) ? first_reg - CW'(1) : '0;
    assign rd_addr = cmd.search_rd ? AW'(first_reg + (cnt_reg >> 1)) :
                     cmd.rd_s1 ? AW'(s_idx + CW'(1)) : AW'(s_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.append && count_reg < CW'(MAX_POINTS))
            mem[AW'(count_reg)] <= {point_speed, point_lon, point_lat, point_time};
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.clear)
            count_reg <= '0;
        else if (cmd.append && count_reg < CW'(MAX_POINTS))
            count_reg <= count_reg + CW'(1);
    end

    // signed compare of adjusted time against stored time
    logic le;
    assign le = !($signed(pos_reg) < $signed({1'b0, rd_reg[31:0]}));

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            pos_reg    <= {1'b0, query_time} - {1'b0, track_start};
            interp_reg <= interpolate;
            first_reg  <= '0;
            cnt_reg    <= count_reg;
        end
        if (cmd.search_rd)
            step_reg <= cnt_reg >> 1;
        if (cmd.search_upd)
        begin
            if (le)
            begin
                first_reg <= first_reg + step_reg + CW'(1);
                cnt_reg   <= cnt_reg - step_reg - CW'(1);
            end
            else
                cnt_reg <= step_reg;
        end
        if (cmd.cap_s)
        begin
            t0_reg   <= rd_reg[31:0];
            lat0_reg <= rd_reg[63:32];
            lon0_reg <= rd_reg[95:64];
            spd0_reg <= rd_reg[105:96];
        end
        if (cmd.cap_s1)
        begin
            t1_reg   <= rd_reg[31:0];
            lat1_reg <= rd_reg[63:32];
            lon1_reg <= rd_reg[95:64];
        end
    end

    assign stat.empty       = (count_reg == '0);
    assign stat.search_done = (cnt_reg == '0);
    assign stat.use_point   = !interp_reg || ($signed({1'b0, t0_reg}) > $signed(pos_reg))
                              || (s_idx + CW'(1) >= count_reg) || (t1_reg <= t0_reg);

    assign frac  = pos_reg[31:0] - t0_reg;
    assign whole = t1_reg - t0_reg;
    assign diff  = lon_phase_reg ? ({lon1_reg[31], lon1_reg} - {lon0_reg[31], lon0_reg})
                                 : ({lat1_reg[31], lat1_reg} - {lat0_reg[31], lat0_reg});

    // lat then lon through the shared multiplier and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg    <= D_IDLE;
            lon_phase_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            case (dstate_reg)
                D_IDLE:
                begin
                    if (cmd.div_start)
                    begin
                        lon_phase_reg <= 1'b0;
                        dstate_reg    <= D_MAG;
                    end
                end
                D_MAG:
                begin
                    dstate_reg <= D_MUL;
                end
                D_MUL:
                begin
                    div_start_reg <= 1'b1;
                    dstate_reg    <= D_DIV;
                end
                D_DIV:
                begin
                    if (div_done)
                    begin
                        if (!lon_phase_reg)
                        begin
                            lon_phase_reg <= 1'b1;
                            dstate_reg    <= D_MAG;
                        end
                        else
                            dstate_reg <= D_IDLE;
                    end
                end
                default: dstate_reg <= D_IDLE;
            endcase
        end
    end

    logic [31:0] base, res;
    assign base = lon_phase_reg ? lon0_reg : lat0_reg;
    assign res  = neg_reg ? base - quot[31:0] : base + quot[31:0];
    assign stat.div_done = div_done && lon_phase_reg;

    always_ff @(posedge clk)
    begin
        if (dstate_reg == D_MAG)
        begin
            neg_reg <= diff[32];
            mag_reg <= diff[32] ? (~diff + 33'd1) : diff;
        end
        if (dstate_reg == D_MUL)
            prod_reg <= 64'(mag_reg) * 64'(frac);
        if (dstate_reg == D_DIV && div_done && !lon_phase_reg)
            lat_res_reg <= res;
    end

    tti_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (whole),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_empty)
        begin
            found_reg <= 1'b0; out_lat_reg <= '0; out_lon_reg <= '0;
            out_speed_reg <= '0; out_time_reg <= '0;
        end
        else if (cmd.out_point)
        begin
            found_reg <= 1'b1; out_lat_reg <= lat0_reg; out_lon_reg <= lon0_reg;
            out_speed_reg <= spd0_reg; out_time_reg <= t0_reg;
        end
        else if (cmd.out_interp)
        begin
            found_reg <= 1'b1; out_lat_reg <= lat_res_reg; out_lon_reg <= res;
            out_speed_reg <= spd0_reg; out_time_reg <= pos_reg[31:0];
        end
    end

    assign found     = found_reg;
    assign out_lat   = out_lat_reg;
    assign out_lon   = out_lon_reg;
    assign out_speed = out_speed_reg;
    assign out_time  = out_time_reg;

endmodule

/* rtl/core/tti_ctrl.sv */
// sequencer for table updates, binary search and interpolation
module tti_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     action,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output tti_pkg::cmd_t  cmd,
    input  tti_pkg::stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SUPD, S_RS, S_RS1, S_CS, S_CS1, S_DEC, S_DIV, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   acc;

    assign out_valid = out_valid_reg;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign acc = in_valid && in_ready;

    always_comb
    begin
        cmd = '0;
        cmd.clear       = acc && action == tti_pkg::ACT_CLEAR;
        cmd.append      = acc && action == tti_pkg::ACT_APPEND;
        cmd.start_query = acc && action == tti_pkg::ACT_QUERY;
        cmd.out_empty   = cmd.start_query && stat.empty;
        cmd.search_rd   = state_reg == S_SRD;
        cmd.search_upd  = state_reg == S_SUPD;
        cmd.rd_s1       = state_reg == S_RS1;
        cmd.cap_s       = state_reg == S_RS1;
        cmd.cap_s1      = state_reg == S_CS;
        cmd.out_point   = state_reg == S_DEC && stat.use_point;
        cmd.div_start   = state_reg == S_DEC && !stat.use_point;
        cmd.out_interp  = state_reg == S_DIV && stat.div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.start_query)
                    begin
                        if (stat.empty)
                            out_valid_reg <= 1'b1;
                        else
                            state_reg <= S_SRD;
                    end
                end
                S_SRD:  state_reg <= stat.search_done ? S_RS : S_SUPD;
                S_SUPD: state_reg <= S_SRD;
                S_RS:   state_reg <= S_RS1;
                S_RS1:  state_reg <= S_CS;
                S_CS:   state_reg <= S_CS1;
                S_CS1:  state_reg <= S_DEC;
                S_DEC:
                begin
                    if (stat.use_point)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (stat.div_done)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/timed_track_interpolator.sv */
// top level of the timed track interpolator
// usage:
//   s_axis carries one action beat (clear, append point, query). clear and
//   append give no result; a query gives one m_axis beat. track_start is
//   written through cfg_we/cfg_wdata; the user must do so only while the
//   block is idle, the block itself does not enforce this. a query result
//   comes from a binary search over the table memory, each halving step
//   taking a read state and an update state; an empty table answers in the
//   cycle after the query is accepted. interpolating then works latitude and
//   longitude in turn, each with a magnitude step, one multiply and a
//   bit-serial divide.
//   one item is worked on at a time; s_axis_tready is low while a query runs
//   or while its result waits in the output register.
//   reset empties the table (count cleared, memory contents left as is) and
//   sets track_start to zero.
//   a stalled m_axis_tready holds the result and blocks new input beats.
module timed_track_interpolator #(
    parameter int MAX_POINTS = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0], point_time[33:2], point_lat[65:34], point_lon[97:66],
    // point_speed[107:98], query_time[139:108], interpolate[140], zero pad
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found[0], out_lat[32:1], out_lon[64:33], out_speed[74:65],
    // out_time[106:75], zero pad
    output logic [111:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    tti_pkg::cmd_t  cmd;
    tti_pkg::stat_t stat;
    logic [31:0] track_start_reg;
    logic        found;
    logic [31:0] out_lat, out_lon, out_time;
    logic [9:0]  out_speed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            track_start_reg <= '0;
        else if (cfg_we)
            track_start_reg <= cfg_wdata;
    end

    tti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .action    (s_axis_tdata[1:0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    tti_datapath #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CW(CW)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .track_start (track_start_reg),
        .point_time  (s_axis_tdata[33:2]),
        .point_lat   (s_axis_tdata[65:34]),
        .point_lon   (s_axis_tdata[97:66]),
        .point_speed (s_axis_tdata[107:98]),
        .query_time  (s_axis_tdata[139:108]),
        .interpolate (s_axis_tdata[140]),
        .found       (found),
        .out_lat     (out_lat),
        .out_lon     (out_lon),
        .out_speed   (out_speed),
        .out_time    (out_time)
    );

    assign m_axis_tdata = {5'd0, out_time, out_speed, out_lon, out_lat, found};

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.append, cmd.start_query})) else $error("multiple commands");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

/* tb/tb_timed_track_interpolator.sv */
// testbench for timed_track_interpolator: directed and random action beats checked against a local predictor
module tb_timed_track_interpolator;

    localparam int DEPTH       = 4096;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        bit        found;
        bit [31:0] lat;
        bit [31:0] lon;
        bit [9:0]  speed;
        bit [31:0] tm;
    } fix_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;

    timed_track_interpolator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // predictor state
    bit [31:0] trk_times [DEPTH];
    bit [31:0] trk_lats  [DEPTH];
    bit [31:0] trk_lons  [DEPTH];
    bit [9:0]  trk_speeds[DEPTH];
    int        trk_count;
    bit [31:0] trk_start;
    bit [31:0] trk_start_sched;

    logic [143:0] pending_beats[$];
    fix_t         expected_fixes[$];
    int           errors;
    int           tx_idle_pct;
    int           rx_idle_pct;
    bit           rx_hold_req;
    int           rx_hold_left;
    int           quiet_cycles;
    bit [31:0]    seq_times[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit [31:0] lerp32(bit [31:0] a32, bit [31:0] b32,
                                         bit [63:0] frac, bit [63:0] whole);
        longint    a;
        longint    b;
        longint    diff;
        bit [63:0] mag;
        bit [63:0] q;
        longint    r;
        a    = longint'($signed(a32));
        b    = longint'($signed(b32));
        diff = b - a;
        mag  = (diff >= 0) ? diff : -diff;
        q    = mag * frac / whole;
        r    = (diff >= 0) ? a + longint'(q) : a - longint'(q);
        return r[31:0];
    endfunction

    // apply one accepted beat to the track table, queue a fix for queries
    task automatic track_accept(input logic [143:0] d);
        bit [1:0]  act;
        bit [31:0] qt;
        longint    pos;
        int        first;
        int        cnt;
        int        step;
        int        mid;
        int        s;
        fix_t      f;
        act = d[1:0];
        if (act == tti_pkg::ACT_CLEAR)
        begin
            trk_count = 0;
        end
        else if (act == tti_pkg::ACT_APPEND)
        begin
            if (trk_count < DEPTH)
            begin
                trk_times[trk_count]  = d[33:2];
                trk_lats[trk_count]   = d[65:34];
                trk_lons[trk_count]   = d[97:66];
                trk_speeds[trk_count] = d[107:98];
                trk_count++;
            end
        end
        else if (act == tti_pkg::ACT_QUERY)
        begin
            if (trk_count == 0)
            begin
                f = '{0, 0, 0, 0, 0};
            end
            else
            begin
                qt    = d[139:108];
                pos   = longint'({32'd0, qt}) - longint'({32'd0, trk_start});
                first = 0;
                cnt   = trk_count;
                while (cnt > 0)
                begin
                    step = cnt / 2;
                    mid  = first + step;
                    if (!(pos < longint'({32'd0, trk_times[mid]})))
                    begin
                        first = mid + 1;
                        cnt   = cnt - step - 1;
                    end
                    else
                        cnt = step;
                end
                s = (first != 0) ? first - 1 : 0;
                f = '{1, trk_lats[s], trk_lons[s], trk_speeds[s], trk_times[s]};
                if (d[140] && longint'({32'd0, trk_times[s]}) <= pos &&
                    s + 1 < trk_count && trk_times[s + 1] > trk_times[s])
                begin
                    f.lat = lerp32(trk_lats[s], trk_lats[s + 1],
                                   pos - longint'({32'd0, trk_times[s]}),
                                   {32'd0, trk_times[s + 1] - trk_times[s]});
                    f.lon = lerp32(trk_lons[s], trk_lons[s + 1],
                                   pos - longint'({32'd0, trk_times[s]}),
                                   {32'd0, trk_times[s + 1] - trk_times[s]});
                    f.tm  = pos[31:0];
                end
            end
            expected_fixes.push_back(f);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic         nxt_valid;
        logic [143:0] nxt_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            nxt_valid = s_axis_tvalid;
            nxt_data  = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_accept(s_axis_tdata);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_beats.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct)
            begin
                nxt_valid = 1'b1;
                nxt_data  = pending_beats.pop_front();
            end
            s_axis_tvalid <= nxt_valid;
            s_axis_tdata  <= nxt_data;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        fix_t f;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_fixes.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    f = expected_fixes.pop_front();
                    if (m_axis_tdata[0] !== f.found)
                    begin
                        $display("%0t: found exp %0d got %0d", $time, f.found,
                                 m_axis_tdata[0]);
                        errors++;
                    end
                    if (m_axis_tdata[32:1] !== f.lat)
                    begin
                        $display("%0t: out_lat exp %h got %h", $time, f.lat,
                                 m_axis_tdata[32:1]);
                        errors++;
                    end
                    if (m_axis_tdata[64:33] !== f.lon)
                    begin
                        $display("%0t: out_lon exp %h got %h", $time, f.lon,
                                 m_axis_tdata[64:33]);
                        errors++;
                    end
                    if (m_axis_tdata[74:65] !== f.speed)
                    begin
                        $display("%0t: out_speed exp %h got %h", $time, f.speed,
                                 m_axis_tdata[74:65]);
                        errors++;
                    end
                    if (m_axis_tdata[106:75] !== f.tm)
                    begin
                        $display("%0t: out_time exp %h got %h", $time, f.tm,
                                 m_axis_tdata[106:75]);
                        errors++;
                    end
                end
            end
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_hold_left  <= 400;
                m_axis_tready <= 1'b0;
            end
            else if (rx_hold_left > 0)
            begin
                rx_hold_left  <= rx_hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_timed_track_interpolator failed");
            $finish;
        end
    end

    function automatic void push_beat(bit [1:0] act, bit [31:0] ptime, bit [31:0] lat,
                                      bit [31:0] lon, bit [9:0] spd, bit [31:0] qtime,
                                      bit interp);
        pending_beats.push_back({3'b0, interp, qtime, spd, lon, lat, ptime, act});
    endfunction

    function automatic void push_query(bit [31:0] qtime, bit interp);
        push_beat(tti_pkg::ACT_QUERY, $urandom, $urandom, $urandom, 10'($urandom),
                  qtime, interp);
    endfunction

    // a clear, a run of points with mostly rising times, then queries mostly near them
    function automatic void push_track_sequence();
        int        n;
        bit [31:0] t;
        bit [31:0] rel;
        int        k;
        n = $urandom_range(12, 1);
        t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000);
        seq_times.delete();
        push_beat(tti_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, 10'($urandom),
                  $urandom, 1'($urandom));
        for (int i = 0; i < n; i++)
        begin
            seq_times.push_back(t);
            push_beat(tti_pkg::ACT_APPEND, t, $urandom, $urandom, 10'($urandom),
                      $urandom, 1'($urandom));
            case ($urandom_range(5))
                0:       t = t;
                1:       t = t + $urandom;
                2:       t = t - $urandom_range(50);
                default: t = t + $urandom_range(2000, 1);
            endcase
        end
        for (int i = 0; i < $urandom_range(6, 2); i++)
        begin
            k   = $urandom_range(n - 1);
            rel = seq_times[k] + $urandom_range(3000) - 200;
            if ($urandom_range(9) == 0)
                rel = $urandom;
            push_query(rel + trk_start_sched, $urandom_range(3) != 0);
        end
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_fixes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start(input bit [31:0] v);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        trk_start       = v;
        trk_start_sched = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int items);
        int target;
        target = pending_beats.size() + items;
        while (pending_beats.size() < target)
        begin
            if ($urandom_range(4) == 0)
                push_beat(2'($urandom), $urandom, $urandom, $urandom, 10'($urandom),
                          $urandom, 1'($urandom));
            else
                push_track_sequence();
        end
    endtask

    initial
    begin
        errors          = 0;
        trk_count       = 0;
        trk_start       = 0;
        trk_start_sched = 0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_req     = 1'b0;
        quiet_cycles    = 0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        rst_n           = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, unused action, lerp extremes
        write_start(32'd0);
        push_query(32'hFFFF_FFFF, 1'b1);
        push_beat(tti_pkg::ACT_UNUSED, '1, '1, '1, '1, '1, 1'b1);
        push_beat(tti_pkg::ACT_APPEND, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF, 10'h3FF,
                  0, 1'b0);
        push_beat(tti_pkg::ACT_APPEND, 32'd100, 32'h0000_0001, 32'h0000_0002, 10'h000,
                  0, 1'b0);
        push_beat(tti_pkg::ACT_APPEND, 32'd1100, 32'h7FFF_FFFF, 32'h8000_0000, 10'h155,
                  0, 1'b0);
        push_beat(tti_pkg::ACT_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 10'h2AA,
                  0, 1'b0);
        push_query(32'd0, 1'b1);
        push_query(32'd100, 1'b1);
        push_query(32'd600, 1'b1);
        push_query(32'd600, 1'b0);
        push_query(32'd1099, 1'b1);
        push_query(32'hFFFF_FFFE, 1'b1);
        push_query(32'hFFFF_FFFF, 1'b1);
        push_beat(tti_pkg::ACT_CLEAR, 0, 0, 0, 10'd0, 0, 1'b0);
        push_query(32'd100, 1'b1);
        push_beat(tti_pkg::ACT_APPEND, 32'd50, 32'd10, 32'd10, 10'd7, 0, 1'b0);
        push_beat(tti_pkg::ACT_APPEND, 32'd10, 32'd20, 32'd20, 10'd8, 0, 1'b0);
        push_query(32'd30, 1'b1);
        push_query(32'd60, 1'b1);

        // query before start with the largest offset
        write_start(32'hFFFF_FFFF);
        push_query(32'd5, 1'b1);
        push_query(32'hFFFF_FFFF, 1'b1);

        tx_idle_pct = 34;
        rx_idle_pct = 73;
        random_phase(130);

        // long receiver hold while the sender keeps offering
        wait_idle();
        rx_hold_req = 1'b1;
        push_track_sequence();
        for (int i = 0; i < 8; i++)
            push_query($urandom, 1'b1);

        write_start($urandom);
        tx_idle_pct = 73;
        rx_idle_pct = 34;
        random_phase(130);

        write_start(32'd1000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(130);

        wait_idle();
        push_beat(tti_pkg::ACT_CLEAR, 0, 0, 0, 10'd0, 0, 1'b0);
        push_query(32'd1000, 1'b1);

        wait_idle();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb_timed_track_interpolator passed");
        else
            $display("tb_timed_track_interpolator failed");
        $finish;
    end

endmodule
